### rtl/hmbt_pkg.sv
// ----------------------------------------------------------------------------
// hmbt_pkg
// Shared types, codes and default sizes for the hash multiset bucket table.
// ----------------------------------------------------------------------------
package hmbt_pkg;

  localparam int DEF_BUCKETS    = 16;
  localparam int DEF_SLOTS      = 8;
  localparam int DEF_VALUE_BITS = 16;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_META,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] bucket_fill;
  } out_t;

endpackage

### rtl/hmbt_fifo.sv
// ----------------------------------------------------------------------------
// hmbt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hmbt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/hmbt_front.sv
// ----------------------------------------------------------------------------
// hmbt_front
// Request side: trim the value, derive its bucket and queue the request.
// ----------------------------------------------------------------------------
module hmbt_front
  import hmbt_pkg::*;
#(
  parameter int BUCKETS    = DEF_BUCKETS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int BKT_W      = $clog2(BUCKETS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_t                   req,
  output logic                  full,
  output logic                  req_valid,
  output logic                  req_cmd,
  output logic [VALUE_BITS-1:0] req_value,
  output logic [BKT_W-1:0]      req_bucket,
  input  logic                  req_pop
);

  localparam int QW = 1 + VALUE_BITS + BKT_W;

  logic [VALUE_BITS+15:0]      val_ext;
  logic [VALUE_BITS-1:0]       val_trim;
  logic [VALUE_BITS+BKT_W-1:0] bkt_ext;
  logic [QW-1:0]               q_wdata;
  logic [QW-1:0]               q_rdata;
  logic                        q_empty;

  // Cut the value to VALUE_BITS, then take its low bits as the bucket.
  assign val_ext  = {{VALUE_BITS{1'b0}}, req.value};
  assign val_trim = val_ext[VALUE_BITS-1:0];
  assign bkt_ext  = {{BKT_W{1'b0}}, val_trim};
  assign q_wdata  = {req.cmd, val_trim, bkt_ext[BKT_W-1:0]};

  hmbt_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (req_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign req_valid  = !q_empty;
  assign req_cmd    = q_rdata[QW-1];
  assign req_value  = q_rdata[QW-2:BKT_W];
  assign req_bucket = q_rdata[BKT_W-1:0];

endmodule

### rtl/hmbt_back.sv
// ----------------------------------------------------------------------------
// hmbt_back
// Table engine: per-bucket count/valid memory, slot value memory, and the
// sequencer that inserts, scans and removes.
// ----------------------------------------------------------------------------
module hmbt_back
  import hmbt_pkg::*;
#(
  parameter int BUCKETS          = DEF_BUCKETS,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS,
  parameter int VALUE_BITS       = DEF_VALUE_BITS,
  parameter int BKT_W            = $clog2(BUCKETS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_cmd,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic [BKT_W-1:0]      req_bucket,
  output logic                  req_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output out_t                  res,
  output logic                  clearing
);

  localparam int S      = SLOTS_PER_BUCKET;
  localparam int SLOT_W = (S > 1) ? $clog2(S) : 1;
  localparam int RI_W   = SLOT_W + 1;
  localparam int CNT_W  = $clog2(S + 1);
  localparam int META_W = CNT_W + S;
  localparam int ADDR_W = $clog2(BUCKETS * S);

  // Per-bucket row: {count, valid mask}; cleared by a pass after reset.
  logic [META_W-1:0]     meta_mem [BUCKETS];
  logic [VALUE_BITS-1:0] val_mem  [BUCKETS * S];

  state_t                state;
  state_t                state_next;

  logic                  item_cmd;
  logic [VALUE_BITS-1:0] item_v;
  logic [BKT_W-1:0]      item_bucket;
  logic [META_W-1:0]     meta_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [BKT_W-1:0]      clr_idx;
  logic [RI_W-1:0]       rd_idx;
  logic                  cmp_pending;
  logic [SLOT_W-1:0]     cmp_idx;
  out_t                  res_next;

  logic [CNT_W-1:0]      cnt;
  logic [S-1:0]          mask;
  logic [SLOT_W-1:0]     free_idx;
  logic [S-1:0]          free_bit;
  logic [S-1:0]          hit_bit;
  logic                  hit;
  logic                  last;
  logic                  meta_we;
  logic [BKT_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic                  val_we;
  logic                  val_re;
  logic [SLOT_W-1:0]     slot_sel;
  logic [ADDR_W-1:0]     val_addr;
  logic [CNT_W+3:0]      fill_ext;
  logic [CNT_W-1:0]      fill_cnt;

  assign cnt  = meta_rd[META_W-1:S];
  assign mask = meta_rd[S-1:0];

  // Lowest free slot of the bucket.
  always_comb begin
    free_idx = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (!mask[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    free_bit           = '0;
    free_bit[free_idx] = 1'b1;
    hit_bit            = '0;
    hit_bit[cmp_idx]   = 1'b1;
  end

  assign hit  = cmp_pending && mask[cmp_idx] && (val_rd == item_v);
  assign last = cmp_pending && (cmp_idx == SLOT_W'(S - 1));

  assign slot_sel = (state == S_META) ? free_idx : rd_idx[SLOT_W-1:0];
  assign val_addr = ADDR_W'(int'(item_bucket) * S + int'(slot_sel));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == BKT_W'(BUCKETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_META;
      end
      S_META: begin
        state_next = (item_cmd == CMD_INSERT) ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        if (hit || last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!res_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    req_pop    = 1'b0;
    res_push   = 1'b0;
    clearing   = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = item_bucket;
    meta_wdata = meta_rd;
    val_we     = 1'b0;
    val_re     = 1'b0;
    fill_cnt   = cnt;
    res_next   = res;
    case (state)
      S_CLEAR: begin
        clearing   = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
      end
      S_IDLE: begin
        req_pop = req_valid;
      end
      S_META: begin
        if (item_cmd == CMD_INSERT) begin
          if (cnt >= CNT_W'(S)) begin
            res_next.status = ST_FULL;
          end else begin
            val_we          = 1'b1;
            meta_we         = 1'b1;
            fill_cnt        = cnt + 1'b1;
            meta_wdata      = {fill_cnt, mask | free_bit};
            res_next.status = ST_INSERTED;
          end
        end
      end
      S_SCAN: begin
        val_re = (rd_idx < RI_W'(S));
        if (hit) begin
          meta_we         = 1'b1;
          fill_cnt        = cnt - 1'b1;
          meta_wdata      = {fill_cnt, mask & ~hit_bit};
          res_next.status = ST_REMOVED;
        end else if (last) begin
          res_next.status = ST_NOT_FOUND;
        end
      end
      S_EMIT: begin
        res_push = !res_full;
      end
      default: begin
        req_pop = 1'b0;
      end
    endcase
    fill_ext             = {4'b0000, fill_cnt};
    res_next.bucket_fill = fill_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      rd_idx      <= '0;
      cmp_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == S_META) begin
        rd_idx      <= '0;
        cmp_pending <= 1'b0;
      end else if (state == S_SCAN) begin
        rd_idx      <= rd_idx + 1'b1;
        cmp_pending <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_pop) begin
      item_cmd    <= req_cmd;
      item_v      <= req_value;
      item_bucket <= req_bucket;
    end
    if (state == S_SCAN) begin
      cmp_idx <= rd_idx[SLOT_W-1:0];
    end
    if (state == S_META || state == S_SCAN) begin
      res <= res_next;
    end
  end

  // Bucket row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (req_pop) begin
      meta_rd <= meta_mem[req_bucket];
    end
  end

  // Slot value memory.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_addr] <= item_v;
    end
    if (val_re) begin
      val_rd <= val_mem[val_addr];
    end
  end

endmodule

### rtl/hash_multiset_bucket_table_top.sv
// ----------------------------------------------------------------------------
// hash_multiset_bucket_table_top
// Multiset of unsigned values in a hash table with fixed slots per bucket.
// ----------------------------------------------------------------------------
// Each word pushed is an insert or a remove of a value; each gives exactly one
// result word with a status (inserted, removed, not found, bucket full) and
// the number of entries left in the value's bucket. The bucket is the low
// bits of the value after it is cut to VALUE_BITS. Requests are handled one
// at a time in arrival order: an insert goes through a bucket row read, an
// update and a result; a remove reads the bucket row, then scans the slot
// memory one slot per cycle until it finds the value or passes the last slot,
// then gives its result. A two-word request queue and a two-word result
// queue let both sides stall independently. After reset the block clears
// its bucket rows with full held high.
// ----------------------------------------------------------------------------
module hash_multiset_bucket_table_top
  import hmbt_pkg::*;
#(
  parameter int BUCKETS          = DEF_BUCKETS,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS,
  parameter int VALUE_BITS       = DEF_VALUE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  req,
  output logic full,
  input  logic pop,
  output out_t rsp,
  output logic empty
);

  localparam int              BKT_W     = $clog2(BUCKETS);
  localparam int              OW        = $bits(out_t);
  localparam int              SLOT_EXTW = 32;
  localparam logic [SLOT_EXTW-1:0] SLOTS_EXT = SLOT_EXTW'(SLOTS_PER_BUCKET);
  localparam logic [3:0]      FULL_FILL = SLOTS_EXT[3:0];

  logic                  front_full;
  logic                  clearing;
  logic                  push_ok;
  logic                  req_valid;
  logic                  req_cmd;
  logic [VALUE_BITS-1:0] req_value;
  logic [BKT_W-1:0]      req_bucket;
  logic                  req_pop;
  logic                  res_full;
  logic                  res_push;
  out_t                  res;
  logic [OW-1:0]         rsp_bits;

  // Hold off requests while the bucket rows are being cleared.
  assign full    = front_full || clearing;
  assign push_ok = push && !full;

  hmbt_front #(
    .BUCKETS    (BUCKETS),
    .VALUE_BITS (VALUE_BITS),
    .BKT_W      (BKT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push_ok),
    .req        (req),
    .full       (front_full),
    .req_valid  (req_valid),
    .req_cmd    (req_cmd),
    .req_value  (req_value),
    .req_bucket (req_bucket),
    .req_pop    (req_pop)
  );

  hmbt_back #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .VALUE_BITS       (VALUE_BITS),
    .BKT_W            (BKT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_cmd    (req_cmd),
    .req_value  (req_value),
    .req_bucket (req_bucket),
    .req_pop    (req_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res),
    .clearing   (clearing)
  );

  // Result queue: decouple the engine from the consumer.
  hmbt_fifo #(
    .WIDTH (OW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (rsp_bits),
    .empty (empty)
  );

  assign rsp = out_t'(rsp_bits);

  // The engine never drops a result into a full queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // Coming out of reset the block clears its rows before taking requests.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> full)
    else $error("request port open during clearing pass");

  // A full-bucket result always reports the bucket at capacity.
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    res_push && (res.status == ST_FULL) |-> res.bucket_fill == FULL_FILL)
    else $error("bucket full reported below capacity");

  // A request is taken from the queue only when the engine sees one waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> req_valid && !clearing)
    else $error("request popped from empty queue");

endmodule

### test/tb_hash_multiset_bucket_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_multiset_bucket_table_top
// Self-checking bench for the hash multiset bucket table.
// ----------------------------------------------------------------------------
// A queue of request words is filled up front. It starts with a directed part
// that covers both extreme values, removes that find nothing, duplicates and
// a full bucket. After that come random words aimed at a few busy buckets, so
// that the buckets fill and drain again. A clocked driver offers the words in
// bursts with random gaps. The response side stalls in modes of its own and
// takes one long hold. A mirror of the bucket table predicts every response
// word, and the monitor checks each response word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_hash_multiset_bucket_table_top;
  import hmbt_pkg::*;

  localparam int NB         = DEF_BUCKETS;
  localparam int NS         = DEF_SLOTS;
  localparam int VB         = DEF_VALUE_BITS;
  localparam int HASH_BITS  = $clog2(NB);
  localparam int RAND_WORDS = 2000;
  localparam int SEG_WORDS  = 100;
  localparam int DRAIN_WAIT = 40;       // idle cycles after the last response word
  localparam int LONG_HOLD  = 300;      // one long stretch without pop
  localparam int HOLD_AT    = 700;      // request count that starts the long hold
  localparam int LIMIT      = 400000;

  // A pending request word; drain makes the driver wait for all responses first.
  typedef struct {
    in_t word;
    bit  drain;
  } pend_t;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  in_t  req  = '0;
  logic full;
  logic pop  = 1'b0;
  out_t rsp;
  logic empty;

  hash_multiset_bucket_table_top #(
    .BUCKETS         (NB),
    .SLOTS_PER_BUCKET(NS),
    .VALUE_BITS      (VB)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .req  (req),
    .full (full),
    .pop  (pop),
    .rsp  (rsp),
    .empty(empty)
  );

  // Mirror of the table contents.
  logic [VB-1:0] mirror_val [NB*NS];
  bit            mirror_live[NB*NS];
  int            mirror_fill[NB];

  pend_t pending[$];
  out_t  rsp_due[$];

  int words_offered = 0;
  int words_taken   = 0;
  int rsp_seen      = 0;
  int errors        = 0;
  int cycle_cnt     = 0;
  int peak_due      = 0;
  int full_stalls   = 0;
  int status_hits[4];

  // Apply one request to the mirror and return the response word it must give.
  function automatic out_t table_apply(in_t w);
    logic [VB-1:0] v;
    int            b;
    int            base;
    bit            done;
    out_t          r;
    v    = w.value[VB-1:0];
    b    = int'(v) % NB;
    base = b * NS;
    done = 1'b0;
    if (cmd_e'(w.cmd) == CMD_INSERT) begin
      r.status = ST_FULL;
      if (mirror_fill[b] < NS) begin
        // take the lowest free slot
        for (int s = 0; s < NS; s++) begin
          if (!done && !mirror_live[base+s]) begin
            mirror_val[base+s]  = v;
            mirror_live[base+s] = 1'b1;
            mirror_fill[b]++;
            r.status = ST_INSERTED;
            done     = 1'b1;
          end
        end
      end
    end else begin
      r.status = ST_NOT_FOUND;
      // drop the lowest live copy of the value
      for (int s = 0; s < NS; s++) begin
        if (!done && mirror_live[base+s] && mirror_val[base+s] == v) begin
          mirror_live[base+s] = 1'b0;
          if (mirror_fill[b] > 0) mirror_fill[b]--;
          r.status = ST_REMOVED;
          done     = 1'b1;
        end
      end
    end
    r.bucket_fill = 4'(mirror_fill[b]);
    return r;
  endfunction

  function automatic pend_t mk(cmd_e c, logic [15:0] v, bit drain = 1'b0);
    pend_t p;
    p.word.cmd   = c;
    p.word.value = v;
    p.drain      = drain;
    return p;
  endfunction

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset: held from the start, then released once at a falling edge.
  initial begin
    for (int i = 0; i < NB*NS; i++) begin
      mirror_val[i]  = '0;
      mirror_live[i] = 1'b0;
    end
    for (int i = 0; i < NB; i++) mirror_fill[i] = 0;
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Request driver: hold an offered word until it is taken, then advance.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && words_taken != words_offered) begin
      // hold: the offered word has not been taken yet
      push <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (pending.size() == 0) begin
      push <= 1'b0;
    end else if (pending[0].drain && (rsp_due.size() != 0 || push)) begin
      // pause until every response word so far has come back
      push <= 1'b0;
    end else begin
      req  <= pending[0].word;
      push <= 1'b1;
      void'(pending.pop_front());
      words_offered++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // start a new burst; a quarter of the bursts follow with no gap
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Response side: stall in modes that change every so often, plus one long hold.
  int  pop_mode  = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      pop_mode  = $urandom_range(0, 3);
      mode_left = $urandom_range(30, 200);
    end else begin
      mode_left--;
    end
    if (!hold_done && words_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;                              // no stalls
        1: pop <= ($urandom_range(0, 1) == 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Request monitor: predict each word taken by the block.
  always @(posedge clk) begin
    if (!rst && push) begin
      if (!full) begin
        rsp_due.push_back(table_apply(req));
        words_taken++;
        if (rsp_due.size() > peak_due) peak_due = rsp_due.size();
      end else begin
        full_stalls++;
      end
    end
  end

  // Response monitor: check each word popped against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      rsp_seen++;
      if (rsp_due.size() == 0) begin
        $error("unexpected response word: status %0d bucket_fill %0d",
               rsp.status, rsp.bucket_fill);
        errors++;
      end else begin
        want = rsp_due.pop_front();
        status_hits[want.status]++;
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.bucket_fill !== want.bucket_fill) begin
          $error("bucket_fill: expected %0d, actual %0d",
                 want.bucket_fill, rsp.bucket_fill);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d response words outstanding",
               cycle_cnt, rsp_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int          hot_b[3];
    logic [15:0] hot_hi[6];
    int          ins_pct;
    logic [15:0] v;
    cmd_e        c;

    // Directed part: both extreme values, removes that find nothing.
    pending.push_back(mk(CMD_INSERT, 16'h0000));
    pending.push_back(mk(CMD_INSERT, 16'hFFFF));
    pending.push_back(mk(CMD_REMOVE, 16'hFFFF));
    pending.push_back(mk(CMD_REMOVE, 16'hFFFF));   // nothing left to remove
    pending.push_back(mk(CMD_REMOVE, 16'h1234));   // empty bucket
    // Fill bucket 5 with a duplicate among the entries, then overflow it.
    pending.push_back(mk(CMD_INSERT, 16'h0005));
    pending.push_back(mk(CMD_INSERT, 16'h0015));
    pending.push_back(mk(CMD_INSERT, 16'h0015));
    pending.push_back(mk(CMD_INSERT, 16'h0025));
    pending.push_back(mk(CMD_INSERT, 16'h8005));
    pending.push_back(mk(CMD_INSERT, 16'h7FF5));
    pending.push_back(mk(CMD_INSERT, 16'h0045));
    pending.push_back(mk(CMD_INSERT, 16'hA5A5));
    pending.push_back(mk(CMD_INSERT, 16'hFFF5));   // bucket full
    // Drain the duplicate, then remove an absent value from a busy bucket.
    pending.push_back(mk(CMD_REMOVE, 16'h0015));
    pending.push_back(mk(CMD_REMOVE, 16'h0015));
    pending.push_back(mk(CMD_REMOVE, 16'h0015));
    pending.push_back(mk(CMD_REMOVE, 16'h0035));
    pending.push_back(mk(CMD_INSERT, 16'hAAAA));
    pending.push_back(mk(CMD_INSERT, 16'h5555));
    pending.push_back(mk(CMD_REMOVE, 16'h0000));

    // Random part: each segment works on a few buckets and a small set of values,
    // so removes usually hit and buckets reach full. About one word in ten is noise.
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % SEG_WORDS == 0) begin
        for (int i = 0; i < 3; i++) hot_b[i] = $urandom_range(0, NB - 1);
        for (int i = 0; i < 6; i++) hot_hi[i] = 16'($urandom_range(0, 65535));
        ins_pct = $urandom_range(35, 70);
      end
      if ($urandom_range(0, 9) == 0) begin
        v = 16'($urandom());
        c = cmd_e'($urandom_range(0, 1));
      end else begin
        v = 16'((hot_hi[$urandom_range(0, 5)] << HASH_BITS) | hot_b[$urandom_range(0, 2)]);
        c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
      end
      // pause before the random part and once midway
      pending.push_back(mk(c, v, (n == 0) || (n == RAND_WORDS / 2)));
    end

    @(negedge rst);
    while (pending.size() != 0 || push || rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests, %0d responses: inserted %0d, removed %0d, not found %0d, full %0d",
             words_taken, rsp_seen, status_hits[ST_INSERTED], status_hits[ST_REMOVED],
             status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
    $display("input stalled by full for %0d cycles, up to %0d responses in flight",
             full_stalls, peak_due);
    if (errors == 0 && rsp_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### hash_multiset_bucket_table_top.f
rtl/hmbt_pkg.sv
rtl/hmbt_fifo.sv
rtl/hmbt_front.sv
rtl/hmbt_back.sv
rtl/hash_multiset_bucket_table_top.sv
test/tb_hash_multiset_bucket_table_top.sv
